[rtl/core/b64e_pkg.sv]
// Shared types, constants and character mapping for the base64 stream encoder.
package b64e_pkg;

  // Queue depth between the byte front end and the character back end.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UPPER = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LOWER = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_DIGIT = 8'h30;  // '0'

  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;

  // Position of the next byte within its 3-byte group.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // Input request: one raw byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  // Output request: one encoded character.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_t;

  // Work handed from the front end to the back end: up to four characters.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            last;
  } task_t;

  // Map a sextet onto the standard alphabet.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < SEXTET_LOWER) begin
      return CHAR_UPPER + v8;
    end else if (v < SEXTET_DIGIT) begin
      return CHAR_LOWER + (v8 - {2'b00, SEXTET_LOWER});
    end else if (v < SEXTET_PLUS) begin
      return CHAR_DIGIT + (v8 - {2'b00, SEXTET_DIGIT});
    end else if (v == SEXTET_PLUS) begin
      return CHAR_PLUS;
    end
    return CHAR_SLASH;
  endfunction

endpackage

[rtl/core/b64e_front.sv]
// Front end: accepts bytes, tracks group phase and carry, forms character tasks.
module b64e_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  b64e_pkg::in_t      in_data,
  input  logic               accept,
  output b64e_pkg::task_t    work
);

  b64e_pkg::phase_t phase;
  b64e_pkg::phase_t phase_next;
  logic [3:0]       carry;
  logic [3:0]       carry_next;
  logic [7:0]       b;
  logic             last;

  assign b    = in_data.data_byte;
  assign last = in_data.end_of_message;

  // Advance the group phase and leftover bits.
  always_comb begin
    unique case (phase)
      b64e_pkg::PH_SECOND: begin
        phase_next = b64e_pkg::PH_THIRD;
        carry_next = b[3:0];
      end
      b64e_pkg::PH_THIRD: begin
        phase_next = b64e_pkg::PH_FIRST;
        carry_next = 4'd0;
      end
      default: begin
        phase_next = b64e_pkg::PH_SECOND;
        carry_next = {2'b00, b[1:0]};
      end
    endcase
    if (last) begin
      phase_next = b64e_pkg::PH_FIRST;
      carry_next = 4'd0;
    end
  end

  // Build the characters this byte produces.
  always_comb begin
    work.chars    = '{default: b64e_pkg::CHAR_PAD};
    work.last     = last;
    work.last_idx = 2'd0;
    unique case (phase)
      b64e_pkg::PH_SECOND: begin
        work.chars[0] = b64e_pkg::sextet_char({carry[1:0], b[7:4]});
        work.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
        work.last_idx = last ? 2'd2 : 2'd0;
      end
      b64e_pkg::PH_THIRD: begin
        work.chars[0] = b64e_pkg::sextet_char({carry, b[7:6]});
        work.chars[1] = b64e_pkg::sextet_char(b[5:0]);
        work.last_idx = 2'd1;
      end
      default: begin
        work.chars[0] = b64e_pkg::sextet_char(b[7:2]);
        work.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
        work.last_idx = last ? 2'd3 : 2'd0;
      end
    endcase
  end

  // Hold state until a byte is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= b64e_pkg::PH_FIRST;
      carry <= 4'd0;
    end else if (accept && in_valid) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

[rtl/core/b64e_queue.sv]
// Short task queue between the front end and the back end.
module b64e_queue #(
  parameter int Depth = b64e_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64e_pkg::task_t push_data,
  input  logic            pop,
  output b64e_pkg::task_t pop_data,
  output logic            full,
  output logic            empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  b64e_pkg::task_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntFull);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Store pushed tasks.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/b64e_back.sv]
// Back end: steps through each task and drives one character per cycle while the output is not stalled.
module b64e_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  b64e_pkg::task_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output b64e_pkg::out_t  out_data
);

  b64e_pkg::task_t cur;
  logic [1:0]      idx;
  logic            busy;
  logic            slot_free;
  logic            emit;
  logic            done;

  assign slot_free = !out_valid || !out_stall;
  assign emit      = busy && slot_free;
  assign done      = emit && (idx == cur.last_idx);
  assign q_pop     = !q_empty && (!busy || done);

  // Load the next task or step through the current one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (emit) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  // Output register: hold while stalled, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_char  <= cur.chars[idx];
      out_data.last_char <= cur.last && (idx == cur.last_idx);
    end
  end

endmodule

[rtl/core/base64_stream_encoder.sv]
// Top level of the base64 stream encoder.
//
// Encodes a byte stream into standard base64 characters (A-Z, a-z, 0-9, '+', '/'),
// zero-filling the last partial sextet and padding with '=' on the byte flagged
// end_of_message; the final character carries last_char. A byte is taken and
// turned into a task of one to four characters that waits in a short
// queue; the output side drives one character per cycle from a registered stage
// while out_stall is low, so sustained throughput is set by the output port.
// Input stall rises only when the task queue is full. An accepted byte passes
// through the queue, the back end's task register and the output register
// before its first character appears.
module base64_stream_encoder #(
  parameter int QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  b64e_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output b64e_pkg::out_t out_data
);

  b64e_pkg::task_t work;
  b64e_pkg::task_t q_data;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  b64e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .accept   (accept),
    .work     (work)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (work),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/b64e_checker.sv]
// Port-level checks for the base64 stream encoder, bound to the top level.
module b64e_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input b64e_pkg::out_t out_data
);

  logic [7:0] c;
  logic       legal;
  logic       pad_open;

  assign c = out_data.out_char;
  assign legal = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                 (c >= 8'h30 && c <= 8'h39) || (c == b64e_pkg::CHAR_PLUS) ||
                 (c == b64e_pkg::CHAR_SLASH) || (c == b64e_pkg::CHAR_PAD);

  // Track a pad that still waits for the closing character of its message.
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_open <= 1'b0;
    end else if (out_valid && !out_stall) begin
      pad_open <= (c == b64e_pkg::CHAR_PAD) && !out_data.last_char;
    end
  end

  // A stalled request stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output request dropped or changed while stalled");

  // Reset empties the output stage and frees the input.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  // Only alphabet or pad characters leave the block.
  a_alphabet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> legal)
    else $error("illegal output character");

  // A pad character is only ever followed by another pad within one message.
  a_pad_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && pad_open |-> (c == b64e_pkg::CHAR_PAD))
    else $error("data character after pad");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/sv/tb_base64_stream_encoder.sv]
// Self-checking testbench for the base64 stream encoder: directed table, random messages.
`timescale 1ns / 1ps

module tb_base64_stream_encoder;

  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_BYTES  = 440;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 120;
  localparam int PRINT_CAP     = 50;

  localparam string ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  b64e_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  b64e_pkg::out_t out_data;

  // Encoder state as the predictor sees it
  b64e_pkg::phase_t group_phase = b64e_pkg::PH_FIRST;
  logic [3:0]       carry_bits = 4'd0;

  b64e_pkg::out_t expected_chars[$];
  b64e_pkg::out_t head_char;
  int   mismatches = 0;
  int   bytes_accepted = 0;
  int   burst_left = 0;

  // Directed messages: typed text where it is obvious, empty where the predictor decides
  b64e_pkg::in_t directed_req [DIRECTED_ROWS] = '{
    '{8'h00, 1'b1},
    '{8'hFF, 1'b1},
    '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b1},
    '{8'h4D, 1'b0}, '{8'h61, 1'b0}, '{8'h6E, 1'b1},
    '{8'h4D, 1'b0}, '{8'h61, 1'b1},
    '{8'h4D, 1'b1},
    '{8'hF8, 1'b1},
    '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b1},
    '{8'hF0, 1'b0}, '{8'h0F, 1'b1},
    '{8'h12, 1'b0}, '{8'h34, 1'b0}, '{8'h56, 1'b0}, '{8'h78, 1'b0}, '{8'h9A, 1'b1}
  };
  string directed_text [DIRECTED_ROWS] = '{
    "AA==",
    "/w==",
    "/", "/", "//",
    "T", "W", "Fu",
    "T", "WE=",
    "TQ==",
    "+A==",
    "A", "A", "AA",
    "", "",
    "", "", "", "", ""
  };

  base64_stream_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic logic [7:0] sextet_to_ascii(logic [5:0] idx);
    return ALPHABET[idx];
  endfunction

  // Advance the encoder state by one byte; queue its characters when asked
  function automatic void predict_chars(b64e_pkg::in_t req, bit record);
    logic [7:0] chars [4];
    int         count;
    logic [7:0] b;
    b = req.data_byte;
    case (group_phase)
      b64e_pkg::PH_SECOND: begin
        chars[0] = sextet_to_ascii({carry_bits[1:0], b[7:4]});
        carry_bits = b[3:0];
        group_phase = b64e_pkg::PH_THIRD;
        count = 1;
        if (req.end_of_message) begin
          chars[1] = sextet_to_ascii({b[3:0], 2'b00});
          chars[2] = b64e_pkg::CHAR_PAD;
          count = 3;
        end
      end
      b64e_pkg::PH_THIRD: begin
        chars[0] = sextet_to_ascii({carry_bits, b[7:6]});
        chars[1] = sextet_to_ascii(b[5:0]);
        carry_bits = 4'd0;
        group_phase = b64e_pkg::PH_FIRST;
        count = 2;
      end
      default: begin
        chars[0] = sextet_to_ascii(b[7:2]);
        carry_bits = {2'b00, b[1:0]};
        group_phase = b64e_pkg::PH_SECOND;
        count = 1;
        if (req.end_of_message) begin
          chars[1] = sextet_to_ascii({b[1:0], 4'b0000});
          chars[2] = b64e_pkg::CHAR_PAD;
          chars[3] = b64e_pkg::CHAR_PAD;
          count = 4;
        end
      end
    endcase
    if (req.end_of_message) begin
      group_phase = b64e_pkg::PH_FIRST;
      carry_bits = 4'd0;
    end
    if (record) begin
      for (int i = 0; i < count; i++) begin
        expected_chars.push_back('{out_char: chars[i],
                                   last_char: req.end_of_message && (i == count - 1)});
      end
    end
  endfunction

  // Offer one request and wait for it to be taken
  task automatic send_byte(b64e_pkg::in_t req, string typed);
    int k;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_accepted++;
    if (typed.len() == 0) begin
      predict_chars(req, 1'b1);
    end else begin
      predict_chars(req, 1'b0);
      for (k = 0; k < typed.len(); k++) begin
        expected_chars.push_back('{out_char: typed[k],
                                   last_char: req.end_of_message && (k == typed.len() - 1)});
      end
    end
  endtask

  // Send in bursts; between most bursts, drop valid for a random gap
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_valid <= 1'b0;
        in_data <= b64e_pkg::in_t'(9'($urandom));
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Receiver: stall at a rate that changes per stretch, with one long hold-off
  initial begin
    int  stall_pct;
    int  span;
    bit  held;
    held = 1'b0;
    forever begin
      span = $urandom_range(8, 64);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (span) begin
        @(negedge clk);
        if (!held && bytes_accepted >= HOLD_AFTER) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Check each accepted character against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b",
                                  out_data.out_char, out_data.last_char));
      end else begin
        head_char = expected_chars.pop_front();
        if (out_data.out_char !== head_char.out_char) begin
          report_mismatch($sformatf("out_char %h, want %h",
                                    out_data.out_char, head_char.out_char));
        end
        if (out_data.last_char !== head_char.last_char) begin
          report_mismatch($sformatf("last_char %b, want %b on char %h",
                                    out_data.last_char, head_char.last_char,
                                    head_char.out_char));
        end
      end
    end
  end

  initial begin
    b64e_pkg::in_t req;
    int  random_bytes;
    int  msg_len;
    int  pick;
    random_bytes = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      send_byte(directed_req[row], directed_text[row]);
      pace();
    end

    // Random messages, mostly short, a few long
    while (random_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        msg_len = $urandom_range(1, 6);
      end else if (pick < 95) begin
        msg_len = $urandom_range(7, 20);
      end else begin
        msg_len = $urandom_range(21, 48);
      end
      for (int i = 0; i < msg_len; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          req.data_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
          req.data_byte = 8'($urandom);
        end
        req.end_of_message = (i == msg_len - 1);
        send_byte(req, "");
        pace();
        random_bytes++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then watch for stray characters
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
